@@ rtl/hduart_pkg.sv @@
// Shared types, codes and constants for the half-duplex UART with receive ring.
// No dependencies; every other file except hduart_ram imports this package.
package hduart_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CFG_LEN_W  = 5;
    localparam int LEN_W      = (PTR_W + 1 > CFG_LEN_W) ? PTR_W + 1 : CFG_LEN_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd2;

    localparam logic [7:0]           BIT_PERIOD_RST    = 8'd104;
    localparam logic [7:0]           FIRST_SAMPLE_RST  = 8'd86;
    localparam logic [CFG_LEN_W-1:0] BUFFER_LENGTH_RST = 5'd16;

    // Command codes on the request channel
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Serial frame bit positions
    localparam logic [3:0] DATA_BITS  = 4'd8;
    localparam logic [3:0] STOP_INDEX = 4'd9;
    localparam logic [3:0] DONE_INDEX = 4'd11;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_SEND,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        logic [1:0] command;
        logic       rx_line;
        logic [7:0] tx_byte;
    } req_item_t;

    typedef struct packed {
        logic       tx_line;
        logic       busy_res;
        logic       send_accepted;
        logic       read_valid;
        logic [7:0] read_byte;
    } rsp_item_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       rx_edge;
        logic       rx_line;
        logic [7:0] tx_byte;
    } op_t;

endpackage

@@ rtl/hduart_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on hduart_pkg for the payload structs.
interface hduart_req_if
    import hduart_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hduart_rsp_if
    import hduart_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/hduart_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hduart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/hduart_front.sv @@
// Front end: takes request items, detects rx_line changes, classifies commands.
// Depends on hduart_pkg and hduart_req_if.
module hduart_front
    import hduart_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hduart_req_if.sink    request,
    output logic          push_valid,
    input  logic          push_ready,
    output op_t           push_op
);
    logic     last_rx_reg;
    logic     accept;
    op_kind_t kind;

    assign accept        = request.valid && push_ready;
    assign request.ready = push_ready;
    assign push_valid    = request.valid;

    // line level seen on the previous item; edges depend only on input order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rx_reg <= 1'b1;
        end
        else if (accept)
        begin
            last_rx_reg <= request.data.rx_line;
        end
    end

    // command decode
    always_comb
    begin
        unique case (request.data.command)
            CMD_TICK: kind = OP_TICK;
            CMD_SEND: kind = OP_SEND;
            CMD_READ: kind = OP_READ;
            default:  kind = OP_NONE;
        endcase
    end

    assign push_op.kind    = kind;
    assign push_op.rx_edge = request.data.rx_line != last_rx_reg;
    assign push_op.rx_line = request.data.rx_line;
    assign push_op.tx_byte = request.data.tx_byte;
endmodule

@@ rtl/hduart_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on hduart_pkg.
module hduart_queue
    import hduart_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);
    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

@@ rtl/hduart_back.sv @@
// Back end: UART state machine, configuration registers, ring pointers,
// ring memory and the response register. Depends on hduart_pkg,
// hduart_rsp_if and hduart_ram.
module hduart_back
    import hduart_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  op_t                   pop_op,
    hduart_rsp_if.source          response
);
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    // configuration
    logic [7:0]           bit_period_reg;
    logic [7:0]           first_sample_reg;
    logic [CFG_LEN_W-1:0] buffer_length_reg;

    // UART state
    logic [1:0]       mode_reg,  mode_next;
    logic [3:0]       bit_idx_reg, bit_idx_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       timer_reg, timer_next;
    logic             tx_level_reg, tx_level_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;

    // response register
    logic out_valid_reg;
    logic busy_reg;
    logic accepted_reg, accepted_next;
    logic read_valid_reg, read_valid_next;
    logic tx_line_reg;

    logic             take;
    logic [LEN_W-1:0] len_cfg;
    logic [LEN_W-1:0] ring_len;
    logic [7:0]       timer_dec;
    logic [3:0]       bit_inc;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;

    assign take      = pop_valid && pop_ready;
    assign pop_ready = !out_valid_reg || response.ready;

    // ring length clamped to 2 .. RING_DEPTH
    assign len_cfg  = LEN_W'(buffer_length_reg);
    assign ring_len = (len_cfg < LEN_W'(2)) ? LEN_W'(2) :
                      (len_cfg > LEN_W'(RING_DEPTH)) ? LEN_W'(RING_DEPTH) : len_cfg;

    function automatic logic [PTR_W-1:0] next_index(
        input logic [PTR_W-1:0] idx,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(idx) + LEN_W'(1);
        next_index = (inc >= len) ? '0 : PTR_W'(inc);
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg    <= BIT_PERIOD_RST;
            first_sample_reg  <= FIRST_SAMPLE_RST;
            buffer_length_reg <= BUFFER_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_PERIOD:    bit_period_reg    <= cfg_wdata;
                CFG_FIRST_SAMPLE:  first_sample_reg  <= cfg_wdata;
                CFG_BUFFER_LENGTH: buffer_length_reg <= cfg_wdata[CFG_LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // one item's effect on the UART state
    always_comb
    begin
        mode_next       = mode_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        timer_next      = timer_reg;
        tx_level_next   = tx_level_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        accepted_next   = 1'b0;
        read_valid_next = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        timer_dec       = timer_reg - 8'd1;
        bit_inc         = bit_idx_reg + 4'd1;

        if (take)
        begin
            // a line change while idle starts reception before the command
            if (mode_reg == MODE_IDLE && pop_op.rx_edge)
            begin
                mode_next    = MODE_RX;
                bit_idx_next = 4'd0;
                shift_next   = 8'd0;
                timer_next   = first_sample_reg;
            end
            timer_dec = timer_next - 8'd1;
            bit_inc   = bit_idx_next + 4'd1;

            unique case (pop_op.kind)
                OP_TICK:
                begin
                    if (mode_next != MODE_IDLE)
                    begin
                        timer_next = (timer_dec == 8'd0) ? bit_period_reg : timer_dec;
                    end
                    if (mode_next == MODE_TX && timer_dec == 8'd0)
                    begin
                        bit_idx_next = bit_inc;
                        if (bit_inc <= DATA_BITS)
                        begin
                            tx_level_next = shift_next[0];
                            shift_next    = {1'b0, shift_next[7:1]};
                        end
                        else if (bit_inc == STOP_INDEX)
                        begin
                            tx_level_next = 1'b1;
                        end
                        else if (bit_inc >= DONE_INDEX)
                        begin
                            mode_next    = MODE_IDLE;
                            bit_idx_next = 4'd0;
                        end
                    end
                    else if (mode_next == MODE_RX && timer_dec == 8'd0)
                    begin
                        if (bit_idx_next < DATA_BITS)
                        begin
                            shift_next   = {pop_op.rx_line, shift_next[7:1]};
                            bit_idx_next = bit_inc;
                        end
                        else
                        begin
                            // stop slot: store byte, drop oldest when full
                            ram_we    = 1'b1;
                            head_next = next_index(head_reg, ring_len);
                            if (head_next == tail_reg)
                            begin
                                tail_next = next_index(tail_reg, ring_len);
                            end
                            mode_next    = MODE_IDLE;
                            bit_idx_next = 4'd0;
                        end
                    end
                end
                OP_SEND:
                begin
                    if (mode_next == MODE_IDLE)
                    begin
                        mode_next     = MODE_TX;
                        shift_next    = pop_op.tx_byte;
                        bit_idx_next  = 4'd0;
                        timer_next    = bit_period_reg;
                        tx_level_next = 1'b0;
                        accepted_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (head_reg != tail_reg)
                    begin
                        ram_re          = 1'b1;
                        tail_next       = next_index(tail_reg, ring_len);
                        read_valid_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            bit_idx_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            timer_reg    <= 8'd0;
            tx_level_reg <= 1'b1;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            timer_reg    <= timer_next;
            tx_level_reg <= tx_level_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    // response register; holds while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tx_line_reg    <= tx_level_next;
            busy_reg       <= mode_next != MODE_IDLE;
            accepted_reg   <= accepted_next;
            read_valid_reg <= read_valid_next;
        end
    end

    // ring storage; read data lines up with the response register
    hduart_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (shift_reg),
        .re    (ram_re),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    assign response.valid              = out_valid_reg;
    assign response.data.tx_line       = tx_line_reg;
    assign response.data.busy_res      = busy_reg;
    assign response.data.send_accepted = accepted_reg;
    assign response.data.read_valid    = read_valid_reg;
    assign response.data.read_byte     = read_valid_reg ? ram_rdata : 8'd0;
endmodule

@@ rtl/half_duplex_uart_with_rx_ring_unit.sv @@
// Channel    | Direction | Payload
// request    | in        | command, rx_line, tx_byte
// response   | out       | tx_line, busy_res, send_accepted, read_valid, read_byte
// cfg port   | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// One item per clock sustained while the response is not stalled; a request,
// once accepted, is held in the queue and then passes through the back end
// into the response register. The state update in the back end sets that
// rate. Reset clears control state and the ring pointers; ring contents stay
// undefined until written. While the response stalls, the two-entry queue
// takes up to two more items, then request.ready drops.
//
// Top level of the half-duplex UART with receive ring.
// Depends on hduart_pkg, hduart_if, hduart_front, hduart_queue, hduart_back.
module half_duplex_uart_with_rx_ring_unit
    import hduart_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    hduart_req_if.sink            request,
    hduart_rsp_if.source          response
);
    logic push_valid;
    logic push_ready;
    op_t  push_op;
    logic pop_valid;
    logic pop_ready;
    op_t  pop_op;

    hduart_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    hduart_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    hduart_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .response  (response)
    );

`ifndef NO_ASSERTIONS
    // an accepted send drives the start bit and marks the block busy
    a_send_start: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && response.data.send_accepted
        |-> !response.data.tx_line && response.data.busy_res)
        else $error("accepted send without start bit or busy");

    // an idle block leaves the transmit line high
    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !response.data.busy_res |-> response.data.tx_line)
        else $error("tx line low while idle");

    // an item taken by the back end shows up as a response next cycle
    a_back_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> response.valid)
        else $error("back end lost an item");

    // send and read results never appear on the same item
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && response.data.send_accepted |-> !response.data.read_valid)
        else $error("send and read flagged together");
`endif
endmodule
